// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, command codes and controller/datapath interface types
// for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int BDQ_DEPTH = 16;
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the input item
        logic exec;    // apply push/pop, start a search read at the front
        logic scan;    // compare one entry, fetch the next
        logic finish;  // move the result to the output register
    } bdq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_search;
        logic scan_empty;  // search range is zero entries
        logic hit;
        logic last;        // entry under compare is the last one in range
        logic out_free;
    } bdq_sts_t;

endpackage
`default_nettype wire

// ===== design/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each item passes accept, execute, then (for a search) one compare per entry over
// n = min(search_limit, entry count) entries, ending early on a hit, then finish.
// One item at a time: a new item is not accepted until the last one is through;
// a result still waiting on m_tready holds the next item in its finish state.
// Reset clears pointer, count, controller and output valid; the store keeps its
// contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Double-ended queue of signed 32-bit values in a ring store, with push and
// pop at both ends and a linear search over the leading entries.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IN_W  = ((CMD_W + VALUE_W + CNT_W + 7) / 8) * 8,
    localparam int OUT_W = ((CNT_W + 2 + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // cmd, item_value, search_limit, zero pad
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // entry_count, found, error, zero pad
);

    bdq_ctl_t         ctl;
    bdq_sts_t         sts;
    logic [CNT_W-1:0] out_count;
    logic             out_found;
    logic             out_error;

    bdq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    bdq_datapath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_value  (s_tdata[CMD_W +: VALUE_W]),
        .in_limit  (s_tdata[CMD_W + VALUE_W +: CNT_W]),
        .ctl       (ctl),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_count (out_count),
        .out_found (out_found),
        .out_error (out_error)
    );

    assign m_tdata = OUT_W'({out_error, out_found, out_count});

endmodule
`default_nettype wire

// ===== design/bdq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller state machine: sequences accept, execute, scan and result
// hand-off for one item at a time.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output bdq_ctl_t      ctl,
    input  wire bdq_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.is_search && !sts.scan_empty)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.hit || sts.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/bdq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, front pointer and count, search compare and output register.
// ----------------------------------------------------------------------------
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CMD_W-1:0]   in_cmd,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire logic [CNT_W-1:0]   in_limit,
    input  wire bdq_ctl_t           ctl,
    output bdq_sts_t                sts,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [CNT_W-1:0]        out_count,
    output logic                    out_found,
    output logic                    out_error
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL  = CNT_W'(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [CMD_W-1:0]   cmd_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   lim_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   cmp_cnt_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               found_reg;
    logic               error_reg;
    logic [AW-1:0]      front_reg;
    logic [AW-1:0]      front_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_tvalid_reg;
    logic [CNT_W-1:0]   m_count_reg;
    logic               m_found_reg;
    logic               m_error_reg;

    logic               is_full;
    logic               is_empty;
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      front_inc;
    logic [AW-1:0]      rd_ptr_inc;
    logic [AW:0]        back_sum;
    logic [AW-1:0]      back_idx;
    logic [CNT_W-1:0]   n_calc;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               push_err;
    logic               pop_err;

    assign is_full    = (count_reg == FULL);
    assign is_empty   = (count_reg == '0);
    assign front_dec  = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign front_inc  = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);
    assign rd_ptr_inc = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
    // count < DEPTH whenever this index is used, so one wrap is enough
    assign back_sum   = {1'b0, front_reg} + (AW+1)'(count_reg);
    assign back_idx   = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
    assign n_calc     = (lim_reg > count_reg) ? count_reg : lim_reg;
    assign push_err   = ((cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK)) && is_full;
    assign pop_err    = ((cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_BACK)) && is_empty;

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        we         = 1'b0;
        wr_addr    = back_idx;
        if (ctl.exec)
        begin
            unique case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                        we         = 1'b1;
                        wr_addr    = front_dec;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (!is_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        we         = 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (!is_empty)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rd_addr = ctl.exec ? front_reg : rd_ptr_reg;

    // ring store: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= key_reg;
        end
        if (ctl.exec || ctl.scan)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (ctl.finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= in_cmd;
            key_reg   <= in_value;
            lim_reg   <= in_limit;
            found_reg <= 1'b0;
            error_reg <= 1'b0;
        end
        if (ctl.exec)
        begin
            error_reg   <= push_err || pop_err;
            n_reg       <= n_calc;
            cmp_cnt_reg <= '0;
            rd_ptr_reg  <= front_inc;
        end
        if (ctl.scan)
        begin
            cmp_cnt_reg <= cmp_cnt_reg + CNT_W'(1);
            rd_ptr_reg  <= rd_ptr_inc;
            if (sts.hit)
            begin
                found_reg <= 1'b1;
            end
        end
        if (ctl.finish)
        begin
            m_count_reg <= count_reg;
            m_found_reg <= found_reg;
            m_error_reg <= error_reg;
        end
    end

    assign sts.is_search  = (cmd_reg == CMD_SEARCH);
    assign sts.scan_empty = (n_calc == '0);
    assign sts.hit        = (rd_data_reg == key_reg);
    assign sts.last       = (cmp_cnt_reg == n_reg - CNT_W'(1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign out_count = m_count_reg;
    assign out_found = m_found_reg;
    assign out_error = m_error_reg;

endmodule
`default_nettype wire

// ===== tb/bdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker
// Watches both stream channels of the deque, keeps its own copy of the ring
// store, front index and entry count, and compares every result item with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bdq_checker
    import bdq_pkg::*;
#(
    parameter int CNT_W = $clog2(BDQ_DEPTH + 1),
    parameter int IN_W  = ((CMD_W + VALUE_W + CNT_W + 7) / 8) * 8,
    parameter int OUT_W = ((CNT_W + 2 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             found;
        logic             error;
    } deque_status_t;

    logic [VALUE_W-1:0] slot_mem [BDQ_DEPTH];
    int unsigned        head_idx;
    int unsigned        held;
    deque_status_t      status_q [$];
    int                 mismatches;

    initial mismatches = 0;
    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t bdq_checker: %s", $time, what);
        mismatches++;
    endtask

    // applies one command to the shadow deque and returns the status it yields
    function automatic deque_status_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [VALUE_W-1:0] key,
                                                    input logic [CNT_W-1:0] limit);
        deque_status_t st;
        int unsigned   span;
        st.found = 1'b0;
        st.error = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT:
                if (held >= BDQ_DEPTH)
                    st.error = 1'b1;
                else
                begin
                    head_idx = (head_idx + BDQ_DEPTH - 1) % BDQ_DEPTH;
                    slot_mem[head_idx] = key;
                    held++;
                end
            CMD_PUSH_BACK:
                if (held >= BDQ_DEPTH)
                    st.error = 1'b1;
                else
                begin
                    slot_mem[(head_idx + held) % BDQ_DEPTH] = key;
                    held++;
                end
            CMD_POP_FRONT:
                if (held == 0)
                    st.error = 1'b1;
                else
                begin
                    head_idx = (head_idx + 1) % BDQ_DEPTH;
                    held--;
                end
            CMD_POP_BACK:
                if (held == 0)
                    st.error = 1'b1;
                else
                    held--;
            CMD_SEARCH:
            begin
                span = (limit < held) ? limit : held;
                for (int unsigned i = 0; i < span; i++)
                    if (slot_mem[(head_idx + i) % BDQ_DEPTH] == key)
                        st.found = 1'b1;
            end
            default: ;  // unused codes leave the deque alone
        endcase
        st.count = CNT_W'(held);
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_status_t want;
        logic [CNT_W-1:0] got_count;
        logic got_found;
        logic got_error;
        if (!rst_n)
        begin
            head_idx = 0;
            held     = 0;
            status_q.delete();
            foreach (slot_mem[i])
                slot_mem[i] = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_count = m_tdata[CNT_W-1:0];
                got_found = m_tdata[CNT_W];
                got_error = m_tdata[CNT_W+1];
                if (status_q.size() == 0)
                    report_mismatch($sformatf("result item with nothing outstanding (count %0d)",
                                              got_count));
                else
                begin
                    want = status_q.pop_front();
                    if (got_count !== want.count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  got_count, want.count));
                    if (got_found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  got_found, want.found));
                    if (got_error !== want.error)
                        report_mismatch($sformatf("error %0b, expected %0b",
                                                  got_error, want.error));
                end
            end
            if (s_tvalid && s_tready)
                status_q.push_back(apply_command(s_tdata[CMD_W-1:0],
                                                 s_tdata[CMD_W +: VALUE_W],
                                                 s_tdata[CMD_W+VALUE_W +: CNT_W]));
        end
        pending = status_q.size();
    end

endmodule

// ===== tb/tb_bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search
// Drives command items into the deque: a directed pass over empty and full
// edges, extreme values and search limits, then random command mixes under
// several sender and receiver idling patterns, including a long output stall.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search;
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(BDQ_DEPTH + 1);
    localparam int IN_W  = ((CMD_W + VALUE_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_W = ((CNT_W + 2 + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    localparam int  HOLD_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 200000;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // cmd, item_value, search_limit, zero pad
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // entry_count, found, error, zero pad

    int     fail_count;
    int     pending;
    int     send_idle_pct;
    int     recv_stall_pct;
    logic   hold_request;
    longint cycle_count;
    logic [VALUE_W-1:0] recent_vals [$];

    bounded_deque_with_search i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bdq_checker #(.CNT_W(CNT_W), .IN_W(IN_W), .OUT_W(OUT_W)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_bounded_deque_with_search: FAIL");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_request = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            4, 5:    return VALUE_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                             input logic [CNT_W-1:0] limit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({limit, val, cmd});
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
        begin
            recent_vals.push_back(val);
            if (recent_vals.size() > 32)
                void'(recent_vals.pop_front());
        end
    endtask

    task automatic send_random(input int n_items);
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] val;
        logic [CNT_W-1:0]   limit;
        int push_pct;
        int roll;
        for (int i = 0; i < n_items; i++)
        begin
            // swing between filling and draining so both ends get hit
            push_pct = ((i / 48) % 2) ? 25 : 72;
            roll = $urandom_range(99);
            val  = pick_value();
            if (roll < 3)
                cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            else if (roll < 25)
            begin
                cmd = CMD_SEARCH;
                if (recent_vals.size() > 0 && $urandom_range(99) < 70)
                    val = recent_vals[$urandom_range(recent_vals.size() - 1)];
            end
            else if ($urandom_range(99) < push_pct)
                cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else
                cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            if ($urandom_range(99) < 80)
                limit = CNT_W'($urandom_range(BDQ_DEPTH));
            else
                limit = CNT_W'($urandom_range((1 << CNT_W) - 1, BDQ_DEPTH + 1));
            send_item(cmd, val, limit);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty deque: pops fail, search finds nothing, unused code is a no-op
        send_item(CMD_POP_FRONT, VAL_MAX, '0);
        send_item(CMD_POP_BACK, VAL_MIN, '0);
        send_item(CMD_SEARCH, '0, CNT_W'(BDQ_DEPTH));
        send_item(CMD_UNUSED_HI, '1, '1);

        // fill to capacity with the extremes at both ends
        send_item(CMD_PUSH_FRONT, VAL_MAX, '0);
        for (int i = 0; i < BDQ_DEPTH - 2; i++)
            send_item(CMD_PUSH_BACK, pick_value(), '0);
        send_item(CMD_PUSH_BACK, VAL_MIN, '0);

        // full: both pushes are refused
        send_item(CMD_PUSH_FRONT, 32'h1234_5678, '0);
        send_item(CMD_PUSH_BACK, '1, '0);

        // limit past the count reaches the back; a short limit does not
        send_item(CMD_SEARCH, VAL_MIN, '1);
        send_item(CMD_SEARCH, VAL_MIN, CNT_W'(1));
        send_item(CMD_SEARCH, VAL_MAX, '0);

        // long output stall with the sender still sending items
        hold_request = 1'b1;
        send_random(260);

        send_idle_pct = 75;
        send_random(260);

        send_idle_pct  = 0;
        recv_stall_pct = 75;
        send_random(260);

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        send_random(245);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (BDQ_DEPTH + 8) @(posedge clk);

        if (fail_count == 0)
            $display("tb_bounded_deque_with_search: PASS");
        else
            $display("tb_bounded_deque_with_search: FAIL");
        $finish;
    end

endmodule
